// ----- design/lbc_pkg.sv -----
package lbc_pkg;

   // Code dimensions.
   localparam int unsigned DATA_BITS   = 4;
   localparam int unsigned PARITY_BITS = 3;
   localparam int unsigned CODE_BITS   = DATA_BITS + PARITY_BITS;

   // Fixed field widths of the ports.
   localparam int unsigned WORD_W = 7;
   localparam int unsigned CFG_W  = 12;

   typedef logic [WORD_W-1:0]      word_type;
   typedef logic [CFG_W-1:0]       cfg_type;
   typedef logic [CODE_BITS-1:0]   code_type;
   typedef logic [DATA_BITS-1:0]   data_type;
   typedef logic [PARITY_BITS-1:0] syn_type;
   typedef logic [CODE_BITS-1:0]   match_type;

   typedef enum logic {
      MODE_ENCODE = 1'b0,
      MODE_DECODE = 1'b1
   } mode_type;

   // Stage 1 result: masked word and its syndrome (the parity when encoding).
   typedef struct packed {
      mode_type mode;
      code_type code;
      syn_type  syn;
   } s1_type;

   // Stage 2 result: adds which check rows equal the syndrome.
   typedef struct packed {
      mode_type  mode;
      code_type  code;
      syn_type   syn;
      match_type match;
   } s2_type;

   // Result item.
   typedef struct packed {
      word_type result_word;
      logic     corrected;
      logic     uncorrectable;
   } rsp_type;

   // Row r of the transposed check matrix [P ; I].
   function automatic syn_type check_row(cfg_type cfg, int unsigned r);
      syn_type row;
      row = '0;
      if (r < DATA_BITS) begin
         row = cfg[r*PARITY_BITS +: PARITY_BITS];
      end else begin
         row = syn_type'(1 << (r - DATA_BITS));
      end
      return row;
   endfunction

endpackage

// ----- design/lbc_syndrome.sv -----
module lbc_syndrome (
   input  logic              clock,
   input  logic              reset,
   input  lbc_pkg::cfg_type  cfg,
   input  logic              in_valid,
   output logic              in_ready,
   input  logic              in_mode,
   input  lbc_pkg::word_type in_word,
   output logic              out_valid,
   input  logic              out_ready,
   output lbc_pkg::s1_type   out_data
);

   logic            valid_ff, valid_in;
   lbc_pkg::s1_type data_ff, data_in;

   // The stage takes a new transfer when empty or when its content moves on.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Mask the word to the bits in use and accumulate the check rows it selects.
   always_comb begin
      lbc_pkg::code_type code;
      lbc_pkg::syn_type  syn;
      code = in_word[lbc_pkg::CODE_BITS-1:0];
      if (lbc_pkg::mode_type'(in_mode) == lbc_pkg::MODE_ENCODE) begin
         code = lbc_pkg::code_type'(in_word[lbc_pkg::DATA_BITS-1:0]);
      end
      syn = '0;
      for (int unsigned r = 0; r < lbc_pkg::CODE_BITS; r++) begin
         if (code[r]) begin
            syn = syn ^ lbc_pkg::check_row(cfg, r);
         end
      end
      data_in.mode = lbc_pkg::mode_type'(in_mode);
      data_in.code = code;
      data_in.syn  = syn;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- design/lbc_match.sv -----
module lbc_match (
   input  logic             clock,
   input  logic             reset,
   input  lbc_pkg::cfg_type cfg,
   input  logic             in_valid,
   output logic             in_ready,
   input  lbc_pkg::s1_type  in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output lbc_pkg::s2_type  out_data
);

   logic            valid_ff, valid_in;
   lbc_pkg::s2_type data_ff, data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Compare the syndrome against every row of the check matrix in parallel.
   always_comb begin
      data_in.mode = in_data.mode;
      data_in.code = in_data.code;
      data_in.syn  = in_data.syn;
      for (int unsigned r = 0; r < lbc_pkg::CODE_BITS; r++) begin
         data_in.match[r] = (lbc_pkg::check_row(cfg, r) == in_data.syn);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- design/lbc_correct.sv -----
module lbc_correct (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  lbc_pkg::s2_type  in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output lbc_pkg::rsp_type out_data
);

   logic             valid_ff, valid_in;
   lbc_pkg::rsp_type data_ff, data_in;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   // Pick the lowest matching row, flip that bit and form the result.
   always_comb begin
      lbc_pkg::match_type lowest;
      lbc_pkg::code_type  fixed;
      lowest = in_data.match & lbc_pkg::match_type'(~in_data.match + 1'b1);
      fixed  = in_data.code ^ lowest;
      data_in.corrected     = 1'b0;
      data_in.uncorrectable = 1'b0;
      unique case (in_data.mode)
         lbc_pkg::MODE_ENCODE: begin
            data_in.result_word = lbc_pkg::word_type'(
               {in_data.syn, in_data.code[lbc_pkg::DATA_BITS-1:0]});
         end
         lbc_pkg::MODE_DECODE: begin
            if (in_data.syn == '0) begin
               data_in.result_word =
                  lbc_pkg::word_type'(in_data.code[lbc_pkg::DATA_BITS-1:0]);
            end else if (|in_data.match) begin
               data_in.result_word =
                  lbc_pkg::word_type'(fixed[lbc_pkg::DATA_BITS-1:0]);
               data_in.corrected   = 1'b1;
            end else begin
               data_in.result_word =
                  lbc_pkg::word_type'(in_data.code[lbc_pkg::DATA_BITS-1:0]);
               data_in.uncorrectable = 1'b1;
            end
         end
         default: begin
            data_in.result_word = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ----- design/linear_block_codec.sv -----
// Systematic linear block encoder and single-error syndrome decoder.
// Request channel (req_valid/req_ready): req_mode selects encode (0) or
// decode (1); req_word carries the data bits or the received codeword.
// Response channel (rsp_valid/rsp_ready): rsp_result_word holds the codeword
// or the recovered data bits, with rsp_corrected and rsp_uncorrectable flags.
// The user must write the generator's parity part via csr_wr_en/csr_wr_data
// only while no transfer is in flight; the block itself does not enforce it.
// A request reaches the response through three registered stages: one forms the
// syndrome, one compares it with every check row, and one picks the lowest match
// and fixes the data. One transfer per cycle is kept up while rsp_ready is high.
// Reset clears every stage's valid bit and the parity register to zero.
// When the receiver holds rsp_ready low, each full stage keeps its item and
// req_ready falls once all three stages are full; nothing is lost or repeated.
module linear_block_codec (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_mode,
   input  lbc_pkg::word_type req_word,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lbc_pkg::word_type rsp_result_word,
   output logic              rsp_corrected,
   output logic              rsp_uncorrectable,
   input  logic              csr_wr_en,
   input  lbc_pkg::cfg_type  csr_wr_data
);

   lbc_pkg::cfg_type parity_ff;
   logic             s1_valid, s1_ready, s2_valid, s2_ready;
   lbc_pkg::s1_type  s1_data;
   lbc_pkg::s2_type  s2_data;
   lbc_pkg::rsp_type rsp_data;

   // Parity matrix register.
   always_ff @(posedge clock) begin
      if (reset) begin
         parity_ff <= '0;
      end else if (csr_wr_en) begin
         parity_ff <= csr_wr_data;
      end
   end

   lbc_syndrome u_syndrome (
      .clock     (clock),
      .reset     (reset),
      .cfg       (parity_ff),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_mode   (req_mode),
      .in_word   (req_word),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   lbc_match u_match (
      .clock     (clock),
      .reset     (reset),
      .cfg       (parity_ff),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   lbc_correct u_correct (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_result_word   = rsp_data.result_word;
   assign rsp_corrected     = rsp_data.corrected;
   assign rsp_uncorrectable = rsp_data.uncorrectable;

`ifndef SYNTHESIS
   // A response never claims both a correction and a failure.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_corrected && rsp_uncorrectable))
      else $error("corrected and uncorrectable both set");

   // The request side only stalls when the whole pipeline is full and blocked.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> (rsp_valid && !rsp_ready))
      else $error("request stalled while the pipeline could advance");

   // The pipeline comes out of reset empty.
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule

// ----- test/testbench.sv -----
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int STALL_LIMIT = 2000;
   localparam int PHASES = 8;
   localparam int ITEMS_PER_PHASE = 180;
   // Classic Hamming (7,4) parity rows 011, 101, 110, 111.
   localparam lbc_pkg::cfg_type HAMMING_P = 12'hFAB;

   typedef enum logic [1:0] {
      ROW_WRITE,
      ROW_CHECK,
      ROW_PREDICT
   } row_kind_type;

   typedef struct packed {
      row_kind_type      kind;
      lbc_pkg::mode_type mode;
      lbc_pkg::cfg_type  value;
      lbc_pkg::rsp_type  want;
   } vector_type;

   logic              clock;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic              req_mode = 1'b0;
   lbc_pkg::word_type req_word = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b1;
   lbc_pkg::word_type rsp_result_word;
   logic              rsp_corrected;
   logic              rsp_uncorrectable;
   logic              csr_wr_en = 1'b0;
   lbc_pkg::cfg_type  csr_wr_data = '0;

   lbc_pkg::cfg_type parity_cfg = '0;
   lbc_pkg::rsp_type pending_results[$];
   bit      quiet = 1'b0;
   int      items_sent = 0;
   int      results_checked = 0;
   int      mismatches = 0;
   int      settings_loaded = 0;
   int      rx_stall = 0;
   int      idle_cycles = 0;

   // Directed vectors. ROW_CHECK rows carry a hand-computed response; ROW_PREDICT
   // rows are checked against the predictor; ROW_WRITE rows load the parity part.
   vector_type directed_vectors [24] = '{
      // Parity part all zero after reset: codewords carry zero parity.
      '{ROW_CHECK,   lbc_pkg::MODE_ENCODE, 12'h000, '{7'h00, 1'b0, 1'b0}},
      '{ROW_CHECK,   lbc_pkg::MODE_ENCODE, 12'h07F, '{7'h0F, 1'b0, 1'b0}},
      '{ROW_CHECK,   lbc_pkg::MODE_DECODE, 12'h000, '{7'h00, 1'b0, 1'b0}},
      '{ROW_CHECK,   lbc_pkg::MODE_DECODE, 12'h07F, '{7'h0F, 1'b0, 1'b1}},
      '{ROW_CHECK,   lbc_pkg::MODE_DECODE, 12'h010, '{7'h00, 1'b1, 1'b0}},
      '{ROW_CHECK,   lbc_pkg::MODE_DECODE, 12'h060, '{7'h00, 1'b0, 1'b1}},
      // Every parity row 111.
      '{ROW_WRITE,   lbc_pkg::MODE_ENCODE, 12'hFFF, '{7'h00, 1'b0, 1'b0}},
      '{ROW_CHECK,   lbc_pkg::MODE_ENCODE, 12'h001, '{7'h71, 1'b0, 1'b0}},
      '{ROW_CHECK,   lbc_pkg::MODE_ENCODE, 12'h003, '{7'h03, 1'b0, 1'b0}},
      '{ROW_CHECK,   lbc_pkg::MODE_ENCODE, 12'h00F, '{7'h0F, 1'b0, 1'b0}},
      '{ROW_CHECK,   lbc_pkg::MODE_DECODE, 12'h001, '{7'h00, 1'b1, 1'b0}},
      '{ROW_CHECK,   lbc_pkg::MODE_DECODE, 12'h071, '{7'h01, 1'b0, 1'b0}},
      '{ROW_CHECK,   lbc_pkg::MODE_DECODE, 12'h030, '{7'h00, 1'b0, 1'b1}},
      // Hamming code: every single-bit error is correctable.
      '{ROW_WRITE,   lbc_pkg::MODE_ENCODE, HAMMING_P, '{7'h00, 1'b0, 1'b0}},
      '{ROW_PREDICT, lbc_pkg::MODE_ENCODE, 12'h005, '{7'h00, 1'b0, 1'b0}},
      '{ROW_PREDICT, lbc_pkg::MODE_DECODE, 12'h05B, '{7'h00, 1'b0, 1'b0}},
      '{ROW_PREDICT, lbc_pkg::MODE_DECODE, 12'h07F, '{7'h00, 1'b0, 1'b0}},
      '{ROW_PREDICT, lbc_pkg::MODE_ENCODE, 12'h07A, '{7'h00, 1'b0, 1'b0}},
      // Rows 0, 1 and 4 of the check matrix are all 001: the lowest one wins.
      '{ROW_WRITE,   lbc_pkg::MODE_ENCODE, 12'h009, '{7'h00, 1'b0, 1'b0}},
      '{ROW_CHECK,   lbc_pkg::MODE_DECODE, 12'h010, '{7'h01, 1'b1, 1'b0}},
      '{ROW_PREDICT, lbc_pkg::MODE_DECODE, 12'h002, '{7'h00, 1'b0, 1'b0}},
      '{ROW_PREDICT, lbc_pkg::MODE_ENCODE, 12'h00A, '{7'h00, 1'b0, 1'b0}},
      '{ROW_CHECK,   lbc_pkg::MODE_DECODE, 12'h020, '{7'h00, 1'b1, 1'b0}},
      '{ROW_PREDICT, lbc_pkg::MODE_DECODE, 12'h07E, '{7'h00, 1'b0, 1'b0}}
   };

   linear_block_codec u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_word          (req_word),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_result_word   (rsp_result_word),
      .rsp_corrected     (rsp_corrected),
      .rsp_uncorrectable (rsp_uncorrectable),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Encodes or decodes one word under the given parity part.
   function automatic lbc_pkg::rsp_type codec_predict(lbc_pkg::cfg_type p,
                                                      lbc_pkg::mode_type m,
                                                      lbc_pkg::word_type w);
      lbc_pkg::syn_type  rows [lbc_pkg::CODE_BITS];
      lbc_pkg::syn_type  syn;
      lbc_pkg::code_type code;
      lbc_pkg::rsp_type  res;
      bit                found;
      for (int r = 0; r < lbc_pkg::CODE_BITS; r++) begin
         if (r < lbc_pkg::DATA_BITS) begin
            rows[r] = lbc_pkg::syn_type'(p >> (r * lbc_pkg::PARITY_BITS));
         end else begin
            rows[r] = '0;
            rows[r][r - lbc_pkg::DATA_BITS] = 1'b1;
         end
      end
      res = '0;
      syn = '0;
      found = 1'b0;
      if (m == lbc_pkg::MODE_ENCODE) begin
         for (int r = 0; r < lbc_pkg::DATA_BITS; r++) begin
            if (w[r]) syn ^= rows[r];
         end
         res.result_word = lbc_pkg::word_type'({syn, w[lbc_pkg::DATA_BITS-1:0]});
      end else begin
         code = w[lbc_pkg::CODE_BITS-1:0];
         for (int r = 0; r < lbc_pkg::CODE_BITS; r++) begin
            if (code[r]) syn ^= rows[r];
         end
         // A nonzero syndrome flips the bit of the lowest matching row.
         if (syn != '0) begin
            for (int r = 0; r < lbc_pkg::CODE_BITS; r++) begin
               if (!found && rows[r] == syn) begin
                  code[r] = ~code[r];
                  found = 1'b1;
               end
            end
            res.corrected = found;
            res.uncorrectable = !found;
         end
         res.result_word = lbc_pkg::word_type'(code[lbc_pkg::DATA_BITS-1:0]);
      end
      return res;
   endfunction

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (quiet || pick < 55) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Presents one request and holds it until the transfer happens.
   task automatic send_request(input lbc_pkg::mode_type m, input lbc_pkg::word_type w,
                               input bit typed, input lbc_pkg::rsp_type want);
      int gap;
      req_valid <= 1'b1;
      req_mode <= m;
      req_word <= w;
      do @(posedge clock); while (req_ready !== 1'b1);
      pending_results.push_back(typed ? want : codec_predict(parity_cfg, m, w));
      items_sent++;
      gap = idle_length();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Loads the parity part once every outstanding response has come back.
   task automatic load_parity(input lbc_pkg::cfg_type value);
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      parity_cfg = value;
      settings_loaded++;
   endtask

   // Receiver with random stalls.
   always @(posedge clock) begin
      if (rx_stall == 0) begin
         rx_stall = idle_length();
      end else begin
         rx_stall = rx_stall - 1;
      end
      rsp_ready <= (rx_stall == 0);
   end

   // Compare each response transfer with the oldest expectation.
   always @(posedge clock) begin
      lbc_pkg::rsp_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_ready === 1'b1) begin
         if (pending_results.size() == 0) begin
            $error("response transfer with nothing expected: result_word %h",
                   rsp_result_word);
            mismatches++;
         end else begin
            want = pending_results.pop_front();
            results_checked++;
            if (rsp_result_word !== want.result_word) begin
               $error("result_word: expected %h, actual %h", want.result_word, rsp_result_word);
               mismatches++;
            end
            if (rsp_corrected !== want.corrected) begin
               $error("corrected: expected %b, actual %b", want.corrected, rsp_corrected);
               mismatches++;
            end
            if (rsp_uncorrectable !== want.uncorrectable) begin
               $error("uncorrectable: expected %b, actual %b", want.uncorrectable,
                      rsp_uncorrectable);
               mismatches++;
            end
         end
      end
   end

   // Watchdog on cycles without any transfer.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $display("Timed out after %0d cycles without a transfer.", STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Stimulus: directed vectors, then random phases under several parity parts.
   initial begin
      lbc_pkg::mode_type m;
      lbc_pkg::word_type w;
      lbc_pkg::cfg_type  setting;
      lbc_pkg::rsp_type  enc;
      int                pick;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_vectors[i]) begin
         if (directed_vectors[i].kind == ROW_WRITE) begin
            load_parity(directed_vectors[i].value);
         end else begin
            send_request(directed_vectors[i].mode,
                         lbc_pkg::word_type'(directed_vectors[i].value),
                         directed_vectors[i].kind == ROW_CHECK, directed_vectors[i].want);
         end
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         unique case (phase)
            0: setting = '0;
            1: setting = '1;
            2: setting = HAMMING_P;
            default: setting = lbc_pkg::cfg_type'($urandom_range(0, 4095));
         endcase
         load_parity(setting);
         quiet = (phase % 3 == 2);
         repeat (ITEMS_PER_PHASE) begin
            m = lbc_pkg::mode_type'($urandom_range(0, 1));
            w = lbc_pkg::word_type'($urandom);
            // Decodes are mostly valid codewords with zero, one or two flipped bits.
            if (m == lbc_pkg::MODE_DECODE) begin
               pick = $urandom_range(0, 99);
               if (pick < 90) begin
                  enc = codec_predict(parity_cfg, lbc_pkg::MODE_ENCODE, w);
                  w = enc.result_word;
                  if (pick >= 35) w[$urandom_range(0, lbc_pkg::CODE_BITS - 1)] ^= 1'b1;
                  if (pick >= 80) w[$urandom_range(0, lbc_pkg::CODE_BITS - 1)] ^= 1'b1;
               end
            end
            send_request(m, w, 1'b0, '0);
         end
      end

      // Drain the pipeline, then wait on for any stray responses.
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("Sent %0d requests under %0d parity settings, encode and decode,",
               items_sent, settings_loaded + 1);
      $display("with clean, single-error and multi-error words; %0d responses compared.",
               results_checked);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
design/lbc_pkg.sv
design/lbc_syndrome.sv
design/lbc_match.sv
design/lbc_correct.sv
design/linear_block_codec.sv
test/testbench.sv
